>>> src/sdta_pkg.sv
package sdta_pkg;

	localparam int BIN_W = 32;
	localparam int DIG_N = 10;
	localparam int BCD_W = 4 * DIG_N;
	localparam int IDX_W = $clog2(DIG_N);
	localparam int CNT_W = $clog2(BIN_W);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

endpackage

>>> src/sdta_dabble.sv
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
module sdta_dabble (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sdta_pkg::BIN_W-1:0] bin,
	output logic                      done,
	output logic [sdta_pkg::BCD_W-1:0] bcd
);

	logic                       busy_q;
	logic                       done_q;
	logic [sdta_pkg::CNT_W-1:0] cnt_q;
	logic [sdta_pkg::BIN_W-1:0] sh_q;
	logic [sdta_pkg::BCD_W-1:0] bcd_q;
	logic [sdta_pkg::BCD_W-1:0] adj;

	always_comb begin
		for (int i = 0; i < sdta_pkg::DIG_N; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sdta_pkg::CNT_W'(sdta_pkg::BIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[sdta_pkg::BCD_W-2:0], sh_q[sdta_pkg::BIN_W-1]};
			sh_q  <= {sh_q[sdta_pkg::BIN_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

>>> src/signed_decimal_to_ascii.sv
// Signed 32-bit integer to decimal ASCII text.
// Slave stream: s_tdata carries one two's-complement value per transaction.
// Master stream: one character per transaction, most significant digit first,
// a leading '-' for negative values, no leading zeros; m_tlast marks the final
// character of each number. Zero gives the single character '0'.
// One value is taken at a time; s_tready is high only while the block is idle.
// The magnitude goes through a shift-and-add-3 converter, one bit per cycle,
// then the leading zero digits are skipped (0 to 9), then the characters
// (1 to 11) are sent as m_tready allows. Skipped zeros and digits always
// total ten.
// The last character sits in the output register while the next value is
// already accepted.
// A stalled receiver holds m_tvalid, m_tdata and m_tlast steady and pauses
// character generation; nothing is dropped.
// Reset (arst_n low) empties the output register and returns to idle.
module signed_decimal_to_ascii (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic signed [31:0] s_tdata,  // [31:0] value
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,  // [7:0] char_code
	output logic               m_tlast   // last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t                     state_q;
	logic                       neg_q;
	logic [sdta_pkg::IDX_W-1:0] idx_q;
	logic                       m_tvalid_q;
	logic [7:0]                 m_tdata_q;
	logic                       m_tlast_q;

	logic                       start;
	logic                       conv_done;
	logic [sdta_pkg::BCD_W-1:0] bcd;
	logic [sdta_pkg::BIN_W-1:0] mag;
	logic [3:0]                 digit;
	logic                       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign start    = s_tvalid && s_tready;
	assign mag      = s_tdata[31] ? (sdta_pkg::BIN_W'(0) - s_tdata) : s_tdata;
	assign digit    = bcd[{idx_q, 2'b00} +: 4];
	assign out_free = !m_tvalid_q || m_tready;

	sdta_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.bin    (mag),
		.done   (conv_done),
		.bcd    (bcd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			neg_q      <= 1'b0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						neg_q   <= s_tdata[31];
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						idx_q   <= sdta_pkg::IDX_W'(sdta_pkg::DIG_N - 1);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (idx_q != '0 && digit == 4'd0) begin
						idx_q <= idx_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (neg_q) begin
							m_tdata_q <= sdta_pkg::CHAR_MINUS;
							m_tlast_q <= 1'b0;
							neg_q     <= 1'b0;
						end else begin
							m_tdata_q <= sdta_pkg::CHAR_ZERO + {4'd0, digit};
							m_tlast_q <= (idx_q == '0);
							if (idx_q == '0) begin
								state_q <= ST_IDLE;
							end else begin
								idx_q <= idx_q - 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		conv_done |-> state_q == ST_CONV)
		else $error("converter done outside conversion");

	a_idle_no_sign: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !neg_q)
		else $error("minus sign left pending at idle");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata == sdta_pkg::CHAR_MINUS |-> !m_tlast)
		else $error("minus sign marked last");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata != sdta_pkg::CHAR_MINUS |->
			m_tdata >= sdta_pkg::CHAR_ZERO && m_tdata <= sdta_pkg::CHAR_ZERO + 8'd9)
		else $error("character outside digit range");

	a_skip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SKIP || state_q == ST_EMIT |->
			idx_q <= sdta_pkg::IDX_W'(sdta_pkg::DIG_N - 1))
		else $error("digit index out of range");

endmodule

>>> sim/decimal_text_checker.sv
`timescale 1ns / 1ps

module decimal_text_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	output int          mismatches,
	output int          chars_due
);

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	text_char_t char_q[$];

	// sign first, then digits most significant first, no leading zeros
	function automatic void append_decimal_text(input logic [31:0] value);
		logic [31:0] mag;
		logic [3:0]  digit [sdta_pkg::DIG_N];
		int          ndig;
		mag = value[31] ? 32'd0 - value : value;
		ndig = 0;
		do begin
			digit[ndig] = 4'(mag % 10);
			mag = mag / 10;
			ndig++;
		end while (mag != 0);
		if (value[31])
			char_q.push_back('{code: sdta_pkg::CHAR_MINUS, last: 1'b0});
		for (int k = ndig - 1; k >= 0; k--)
			char_q.push_back('{code: sdta_pkg::CHAR_ZERO + 8'(digit[k]), last: (k == 0)});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			char_q.delete();
			mismatches = 0;
		end else begin
			if (s_tvalid && s_tready)
				append_decimal_text(s_tdata);
			if (m_tvalid && m_tready) begin
				if (char_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected char %h last %b", $realtime, m_tdata,
							m_tlast);
					mismatches = mismatches + 1;
				end else begin
					want = char_q.pop_front();
					if (m_tdata !== want.code || m_tlast !== want.last) begin
						if (mismatches < 10)
							$display("%0t: char exp %h last %b, got %h last %b", $realtime,
								want.code, want.last, m_tdata, m_tlast);
						mismatches = mismatches + 1;
					end
				end
			end
		end
		chars_due = char_q.size();
	end

endmodule

>>> sim/signed_decimal_to_ascii_test.sv
`timescale 1ns / 1ps

module signed_decimal_to_ascii_test;

	localparam int TIMEOUT_CYCLES = 400000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int RANDOM_ITEMS   = 158;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic signed [31:0] s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;
	logic               m_tlast;

	int mismatches;
	int chars_due;
	int cycles;
	int burst_left;
	int ready_run;
	bit stall_phase;

	int directed_values [22] = '{
		0, 1, -1, 5, -5, 9, 10, -10, 99, 100, 2147483647, int'(32'h8000_0000),
		-2147483647, 1000000000, 999999999, -999999999, 1000000001, 123456789,
		-123456789, 1999999999, -1000000000, 2000000000
	};

	signed_decimal_to_ascii uut (.*);

	decimal_text_checker checker_i (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("signed_decimal_to_ascii_test: errors");
			$finish;
		end
	end

	// receiver: alternating ready and stall runs, occasionally long ones
	always @(posedge clk) begin
		if (ready_run > 0) begin
			ready_run--;
		end else begin
			stall_phase = !stall_phase;
			if (stall_phase) begin
				ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25)
					: $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				ready_run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
					: $urandom_range(0, 6);
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [31:0] random_value();
		int unsigned bound;
		logic [31:0] v;
		if ($urandom_range(0, 3) == 0)
			return $urandom();
		bound = 1;
		repeat ($urandom_range(1, 9)) bound *= 10;
		v = $urandom_range(0, bound - 1);
		if ($urandom_range(0, 1))
			v = 32'd0 - v;
		return v;
	endfunction

	task automatic offer_value(input logic [31:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic wait_for_text_drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (chars_due != 0) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		clk      = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_values[i])
			offer_value(directed_values[i]);
		wait_for_text_drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				wait_for_text_drain();
			offer_value(random_value());
		end
		wait_for_text_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("signed_decimal_to_ascii_test: clean");
		end else begin
			$display("signed_decimal_to_ascii_test: errors");
		end
		$finish;
	end

endmodule
